// ===== rtl/core/grc_pkg.sv =====
package grc_pkg;

  // Item kinds
  localparam logic ITEM_WRITE = 1'b0;
  localparam logic ITEM_CAST  = 1'b1;

  // Configuration register indexes
  localparam logic [2:0] REG_POS_X   = 3'd0;
  localparam logic [2:0] REG_POS_Y   = 3'd1;
  localparam logic [2:0] REG_DIR_X   = 3'd2;
  localparam logic [2:0] REG_DIR_Y   = 3'd3;
  localparam logic [2:0] REG_PLANE_X = 3'd4;
  localparam logic [2:0] REG_PLANE_Y = 3'd5;

  // Wall faces
  localparam logic [1:0] FACE_NORTH = 2'd0;
  localparam logic [1:0] FACE_SOUTH = 2'd1;
  localparam logic [1:0] FACE_EAST  = 2'd2;
  localparam logic [1:0] FACE_WEST  = 2'd3;

  localparam logic [3:0]  OUTSIDE_CODE = 4'd15;
  localparam logic [23:0] PERP_SAT     = 24'hFF_FFFF;
  localparam logic [15:0] HEIGHT_SAT   = 16'hFFFF;
  localparam logic [33:0] DELTA_SAT    = 34'h2_0000_0000;
  localparam int          ONE_Q16      = 65536;

  // Divider and datapath widths
  localparam int DIV_W  = 44;  // dividend and quotient
  localparam int DVS_W  = 28;  // divisor
  localparam int CAM_W  = 25;
  localparam int RAY_W  = 28;
  localparam int DD_W   = 34;
  localparam int SD_W   = 59;
  localparam int MX_W   = 9;
  localparam int NUM_W  = 28;

  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

  typedef struct packed {
    logic       kind;
    logic [9:0] column;
    logic [4:0] cell_x;
    logic [4:0] cell_y;
    logic [3:0] cell_code;
  } item_t;

  typedef struct packed {
    logic [3:0]  hit_code;
    logic [4:0]  hit_x;
    logic [4:0]  hit_y;
    logic        hit_side;
    logic [1:0]  wall_face;
    logic [23:0] perp_distance;
    logic [15:0] line_height;
    logic [8:0]  span_start;
    logic [8:0]  span_end;
    logic [5:0]  texture_column;
  } result_t;

  typedef struct packed {
    logic [20:0]        pos_x;
    logic [20:0]        pos_y;
    logic signed [17:0] dir_x;
    logic signed [17:0] dir_y;
    logic signed [17:0] plane_x;
    logic signed [17:0] plane_y;
  } cfg_regs_t;

  // Classified item as held in the queue
  typedef struct packed {
    logic       is_cast;
    logic       wr_ok;
    logic [9:0] column;
    logic [4:0] cell_x;
    logic [4:0] cell_y;
    logic [3:0] cell_code;
  } op_t;

  typedef struct packed {
    logic valid;
    op_t  op;
  } queue_head_t;

endpackage

// ===== rtl/core/grid_ray_caster.sv =====
// Grid ray caster: DDA wall casting over a square grid of 4-bit cell codes.
// Item channel: an item transfers on a rising edge with start high and busy
// low. A write item stores one cell and gives no result; a cast item gives
// exactly one result, shown on result for the single cycle that
// result_valid is high. The receiver cannot stall, so nothing holds it.
// Config channel: cfg_valid/cfg_ready/cfg_index/cfg_data, always ready;
// write registers only while no cast is in flight.
// Items pass through a two-entry queue to the cast engine, so busy rises
// only when that queue is full or during the clearing pass.
// A cast takes four divisions on one shared radix-2 divider, a reciprocal
// multiply for the camera term, a walk of at most 2*GRID_DIM+4 grid steps,
// and set-up, multiply and clamp states; the engine takes its next item at
// the edge that ends the result cycle. A write is done by the engine in its
// idle state.
// Reset: registers load their defaults, the queue empties, and the grid is
// cleared one cell a cycle, GRID_DIM*GRID_DIM cells (1024 by default),
// with busy held high throughout; config writes are still taken.
module grid_ray_caster #(
  parameter int GRID_DIM      = 32,
  parameter int SCREEN_WIDTH  = 640,
  parameter int SCREEN_HEIGHT = 480,
  parameter int TEX_SIZE      = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  grc_pkg::item_t    item,
  output logic              result_valid,
  output grc_pkg::result_t  result,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [2:0]        cfg_index,
  input  logic [20:0]       cfg_data
);

  grc_pkg::cfg_regs_t   cfg;
  grc_pkg::queue_head_t head;
  logic                 take;
  logic                 clearing;

  // Registers accept every transfer; unknown indexes drop the data
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pos_x   <= 21'd753664;
      cfg.pos_y   <= 21'd98304;
      cfg.dir_x   <= -18'sd65536;
      cfg.dir_y   <= 18'sd0;
      cfg.plane_x <= 18'sd0;
      cfg.plane_y <= 18'sd43254;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        grc_pkg::REG_POS_X:   cfg.pos_x   <= cfg_data;
        grc_pkg::REG_POS_Y:   cfg.pos_y   <= cfg_data;
        grc_pkg::REG_DIR_X:   cfg.dir_x   <= signed'(cfg_data[17:0]);
        grc_pkg::REG_DIR_Y:   cfg.dir_y   <= signed'(cfg_data[17:0]);
        grc_pkg::REG_PLANE_X: cfg.plane_x <= signed'(cfg_data[17:0]);
        grc_pkg::REG_PLANE_Y: cfg.plane_y <= signed'(cfg_data[17:0]);
        default: ;
      endcase
    end
  end

  // Front: take and classify items, hold them in the queue
  grc_front #(
    .GRID_DIM (GRID_DIM)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .item     (item),
    .clearing (clearing),
    .take     (take),
    .head     (head),
    .busy     (busy)
  );

  // Back: grid store, walk and result arithmetic
  grc_back #(
    .GRID_DIM      (GRID_DIM),
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT),
    .TEX_SIZE      (TEX_SIZE)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .head         (head),
    .take         (take),
    .clearing     (clearing),
    .result_valid (result_valid),
    .result       (result)
  );

endmodule

// ===== rtl/core/grc_div.sv =====
module grc_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        go,
  input  logic [grc_pkg::DIV_W-1:0]   dividend,
  input  logic [grc_pkg::DVS_W-1:0]   divisor,
  output logic                        done,
  output logic [grc_pkg::DIV_W-1:0]   quotient
);

  localparam int CNT_W = $clog2(grc_pkg::DIV_W + 1);

  logic [grc_pkg::DIV_W-1:0] dvd;
  logic [grc_pkg::DVS_W-1:0] dvs;
  logic [grc_pkg::DVS_W-1:0] rem;
  logic [CNT_W-1:0]          cnt;
  logic                      running;
  logic [grc_pkg::DVS_W:0]   shifted;
  logic [grc_pkg::DVS_W+1:0] diff;

  // One quotient bit per cycle, restoring
  always_comb begin
    shifted = {rem, dvd[grc_pkg::DIV_W-1]};
    diff    = {1'b0, shifted} - {2'b00, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (go) begin
        running <= 1'b1;
        cnt     <= CNT_W'(grc_pkg::DIV_W);
      end else if (running) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      dvd <= dividend;
      dvs <= divisor;
      rem <= '0;
    end else if (running) begin
      if (!diff[grc_pkg::DVS_W+1]) begin
        rem <= diff[grc_pkg::DVS_W-1:0];
        dvd <= {dvd[grc_pkg::DIV_W-2:0], 1'b1};
      end else begin
        rem <= shifted[grc_pkg::DVS_W-1:0];
        dvd <= {dvd[grc_pkg::DIV_W-2:0], 1'b0};
      end
    end
  end

  assign quotient = dvd;

endmodule

// ===== rtl/core/grc_front.sv =====
module grc_front #(
  parameter int GRID_DIM = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  grc_pkg::item_t        item,
  input  logic                  clearing,
  input  logic                  take,
  output grc_pkg::queue_head_t  head,
  output logic                  busy
);

  grc_pkg::op_t                     entries [grc_pkg::QUEUE_DEPTH];
  logic [grc_pkg::QUEUE_PTR_W-1:0]  wr_ptr;
  logic [grc_pkg::QUEUE_PTR_W-1:0]  rd_ptr;
  logic [grc_pkg::QUEUE_PTR_W:0]    count;
  logic                             push;
  logic                             pop;
  grc_pkg::op_t                     op;

  // Classify: casts pass the column, writes check the grid bound here
  always_comb begin
    op.is_cast   = (item.kind == grc_pkg::ITEM_CAST);
    op.wr_ok     = (32'(item.cell_x) < GRID_DIM) && (32'(item.cell_y) < GRID_DIM);
    op.column    = item.column;
    op.cell_x    = item.cell_x;
    op.cell_y    = item.cell_y;
    op.cell_code = item.cell_code;
  end

  assign busy = clearing || (count == (grc_pkg::QUEUE_PTR_W+1)'(grc_pkg::QUEUE_DEPTH));
  assign push = start && !busy;
  assign pop  = take && head.valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= op;
  end

  assign head.valid = (count != '0);
  assign head.op    = entries[rd_ptr];

endmodule

// ===== rtl/core/grc_back.sv =====
module grc_back #(
  parameter int GRID_DIM      = 32,
  parameter int SCREEN_WIDTH  = 640,
  parameter int SCREEN_HEIGHT = 480,
  parameter int TEX_SIZE      = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  input  grc_pkg::cfg_regs_t    cfg,
  input  grc_pkg::queue_head_t  head,
  output logic                  take,
  output logic                  clearing,
  output logic                  result_valid,
  output grc_pkg::result_t      result
);

  localparam int CELLS    = GRID_DIM * GRID_DIM;
  localparam int AW       = $clog2(CELLS);
  localparam int WALK_CAP = 2 * GRID_DIM + 4;
  localparam int IT_W     = $clog2(WALK_CAP);
  localparam int PX_W     = 18 + grc_pkg::CAM_W;
  localparam int PW_W     = 25 + grc_pkg::RAY_W;
  localparam int SP_W     = 17;
  // Camera term: column * 2^17 / SCREEN_WIDTH by reciprocal, exact for
  // every 10-bit column
  localparam int CAM_SH   = 27 + $clog2(SCREEN_WIDTH);
  localparam int CAM_SHR  = CAM_SH - 17;
  localparam logic [28:0] CAM_RECIP =
    29'(((64'd1 << CAM_SH) + 64'(SCREEN_WIDTH) - 64'd1) / 64'(SCREEN_WIDTH));

  typedef enum logic [14:0] {
    S_CLEAR   = 15'b000000000000001,
    S_IDLE    = 15'b000000000000010,
    S_CAM     = 15'b000000000000100,
    S_RAY_MUL = 15'b000000000001000,
    S_RAY_ADD = 15'b000000000010000,
    S_DDX     = 15'b000000000100000,
    S_DDY     = 15'b000000001000000,
    S_SIDE    = 15'b000000010000000,
    S_STEP    = 15'b000000100000000,
    S_LOOK    = 15'b000001000000000,
    S_NUM     = 15'b000010000000000,
    S_PERP    = 15'b000100000000000,
    S_LH      = 15'b001000000000000,
    S_SPAN    = 15'b010000000000000,
    S_TEX     = 15'b100000000000000
  } state_t;

  state_t state;

  // Grid store
  logic [3:0]    mem [CELLS];
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [3:0]    mem_wdata;
  logic [AW-1:0] rd_addr;
  logic [3:0]    rd_data;
  logic [AW-1:0] clr_addr;

  // Divider
  logic                      div_go;
  logic [grc_pkg::DIV_W-1:0] div_a;
  logic [grc_pkg::DVS_W-1:0] div_b;
  logic                      div_done;
  logic [grc_pkg::DIV_W-1:0] div_q;

  // Datapath
  logic [9:0]                       col;
  logic [38:0]                      cam_prod;
  logic signed [grc_pkg::CAM_W-1:0] cam;
  logic signed [PX_W-1:0]           prod_x;
  logic signed [PX_W-1:0]           prod_y;
  logic signed [grc_pkg::RAY_W-1:0] rx;
  logic signed [grc_pkg::RAY_W-1:0] ry;
  logic signed [grc_pkg::RAY_W-1:0] rx_next;
  logic signed [grc_pkg::RAY_W-1:0] ry_next;
  logic [grc_pkg::RAY_W-1:0]        rx_mag;
  logic [grc_pkg::RAY_W-1:0]        ry_mag;
  logic [grc_pkg::DD_W-1:0]         ddx;
  logic [grc_pkg::DD_W-1:0]         ddy;
  logic [grc_pkg::SD_W-1:0]         sdx;
  logic [grc_pkg::SD_W-1:0]         sdy;
  logic [16:0]                      fxc;
  logic [16:0]                      fyc;
  logic signed [grc_pkg::MX_W-1:0]  mx;
  logic signed [grc_pkg::MX_W-1:0]  my;
  logic signed [grc_pkg::MX_W-1:0]  mx_next;
  logic signed [grc_pkg::MX_W-1:0]  my_next;
  logic                             step_x;
  logic                             side;
  logic [IT_W-1:0]                  iter;
  logic [3:0]                       code;
  logic                             outside;
  logic signed [grc_pkg::NUM_W-1:0] num;
  logic [grc_pkg::NUM_W-1:0]        num_mag;
  logic                             rd_zero;
  logic [23:0]                      perp;
  logic [23:0]                      perp_val;
  logic [15:0]                      lh;
  logic [15:0]                      lh_val;
  logic [SP_W-1:0]                  half;
  logic [SP_W-1:0]                  start_val;
  logic [SP_W-1:0]                  end_val;
  logic [8:0]                       span_start;
  logic [8:0]                       span_end;
  logic signed [PW_W-1:0]           prod_w;
  logic [15:0]                      wall16;
  logic [31:0]                      tex_raw;
  logic                             mirror;
  logic [1:0]                       face;

  grc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .go       (div_go),
    .dividend (div_a),
    .divisor  (div_b),
    .done     (div_done),
    .quotient (div_q)
  );

  // Combinational helpers
  always_comb begin
    cam_prod = 39'(col) * 39'(CAM_RECIP);

    rx_next = grc_pkg::RAY_W'(cfg.dir_x) + grc_pkg::RAY_W'(prod_x >>> 16);
    ry_next = grc_pkg::RAY_W'(cfg.dir_y) + grc_pkg::RAY_W'(prod_y >>> 16);
    rx_mag  = rx[grc_pkg::RAY_W-1] ? grc_pkg::RAY_W'(-rx) : grc_pkg::RAY_W'(rx);
    ry_mag  = ry[grc_pkg::RAY_W-1] ? grc_pkg::RAY_W'(-ry) : grc_pkg::RAY_W'(ry);

    fxc = rx[grc_pkg::RAY_W-1] ? {1'b0, cfg.pos_x[15:0]}
                               : 17'h10000 - {1'b0, cfg.pos_x[15:0]};
    fyc = ry[grc_pkg::RAY_W-1] ? {1'b0, cfg.pos_y[15:0]}
                               : 17'h10000 - {1'b0, cfg.pos_y[15:0]};

    step_x  = (sdx < sdy);
    mx_next = mx;
    my_next = my;
    if (step_x) begin
      mx_next = rx[grc_pkg::RAY_W-1] ? mx - 1'b1 : mx + 1'b1;
    end else begin
      my_next = ry[grc_pkg::RAY_W-1] ? my - 1'b1 : my + 1'b1;
    end

    outside = (mx < 0) || (my < 0) || (mx >= GRID_DIM) || (my >= GRID_DIM);

    if (!side) begin
      num = (grc_pkg::NUM_W'(mx) <<< 16)
          - grc_pkg::NUM_W'(signed'({1'b0, cfg.pos_x}))
          + (rx[grc_pkg::RAY_W-1] ? grc_pkg::NUM_W'(grc_pkg::ONE_Q16) : '0);
    end else begin
      num = (grc_pkg::NUM_W'(my) <<< 16)
          - grc_pkg::NUM_W'(signed'({1'b0, cfg.pos_y}))
          + (ry[grc_pkg::RAY_W-1] ? grc_pkg::NUM_W'(grc_pkg::ONE_Q16) : '0);
    end
    num_mag = num[grc_pkg::NUM_W-1] ? grc_pkg::NUM_W'(-num) : grc_pkg::NUM_W'(num);

    if (rd_zero || (div_q > grc_pkg::DIV_W'(grc_pkg::PERP_SAT))) begin
      perp_val = grc_pkg::PERP_SAT;
    end else begin
      perp_val = div_q[23:0];
    end

    if ((perp == '0) || (div_q > grc_pkg::DIV_W'(grc_pkg::HEIGHT_SAT))) begin
      lh_val = grc_pkg::HEIGHT_SAT;
    end else begin
      lh_val = div_q[15:0];
    end

    half = SP_W'(lh[15:1]);
    if (half > SP_W'(SCREEN_HEIGHT / 2)) begin
      start_val = '0;
    end else begin
      start_val = SP_W'(SCREEN_HEIGHT / 2) - half;
    end
    end_val = half + SP_W'(SCREEN_HEIGHT / 2);
    if (end_val >= SP_W'(SCREEN_HEIGHT)) begin
      end_val = SP_W'(SCREEN_HEIGHT - 1);
    end

    wall16  = prod_w[31:16] + (side ? cfg.pos_x[15:0] : cfg.pos_y[15:0]);
    tex_raw = (32'(wall16) * 32'(TEX_SIZE)) >> 16;
    mirror  = side ? ry[grc_pkg::RAY_W-1]
                   : (!rx[grc_pkg::RAY_W-1] && (rx != '0));
    if (mirror) begin
      tex_raw = 32'(TEX_SIZE) - tex_raw - 32'd1;
    end

    if (!side) face = rx[grc_pkg::RAY_W-1] ? grc_pkg::FACE_SOUTH : grc_pkg::FACE_NORTH;
    else       face = ry[grc_pkg::RAY_W-1] ? grc_pkg::FACE_WEST  : grc_pkg::FACE_EAST;
  end

  // Read address follows the cell being stepped into, so the data is ready
  // in the look-up cycle
  assign rd_addr = AW'(32'(mx_next[grc_pkg::MX_W-2:0]) * GRID_DIM
                     + 32'(my_next[grc_pkg::MX_W-2:0]));

  // Memory write port: clearing pass or a write item
  always_comb begin
    take      = (state == S_IDLE) && head.valid;
    mem_we    = 1'b0;
    mem_waddr = clr_addr;
    mem_wdata = '0;
    if (state == S_CLEAR) begin
      mem_we = 1'b1;
    end else if (take && !head.op.is_cast && head.op.wr_ok) begin
      mem_we    = 1'b1;
      mem_waddr = AW'(32'(head.op.cell_x) * GRID_DIM + 32'(head.op.cell_y));
      mem_wdata = head.op.cell_code;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    rd_data <= mem[rd_addr];
  end

  assign clearing = (state == S_CLEAR);

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      clr_addr     <= '0;
      div_go       <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      div_go       <= 1'b0;
      result_valid <= 1'b0;
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == AW'(CELLS - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (take && head.op.is_cast) begin
            state <= S_CAM;
          end
        end
        S_CAM:     state <= S_RAY_MUL;
        S_RAY_MUL: state <= S_RAY_ADD;
        S_RAY_ADD: begin
          div_go <= 1'b1;
          state  <= S_DDX;
        end
        S_DDX: begin
          if (div_done) begin
            div_go <= 1'b1;
            state  <= S_DDY;
          end
        end
        S_DDY:  if (div_done) state <= S_SIDE;
        S_SIDE: state <= S_STEP;
        S_STEP: state <= S_LOOK;
        S_LOOK: begin
          if (outside || (rd_data != '0) || (iter == IT_W'(WALK_CAP - 1))) begin
            state <= S_NUM;
          end else begin
            state <= S_STEP;
          end
        end
        S_NUM: begin
          div_go <= 1'b1;
          state  <= S_PERP;
        end
        S_PERP: begin
          if (div_done) begin
            div_go <= 1'b1;
            state  <= S_LH;
          end
        end
        S_LH:   if (div_done) state <= S_SPAN;
        S_SPAN: state <= S_TEX;
        S_TEX: begin
          result_valid <= 1'b1;
          state        <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        col <= head.op.column;
      end
      S_CAM: begin
        cam <= grc_pkg::CAM_W'(cam_prod >> CAM_SHR) - grc_pkg::CAM_W'(grc_pkg::ONE_Q16);
      end
      S_RAY_MUL: begin
        prod_x <= PX_W'(cfg.plane_x) * PX_W'(cam);
        prod_y <= PX_W'(cfg.plane_y) * PX_W'(cam);
      end
      S_RAY_ADD: begin
        rx    <= rx_next;
        ry    <= ry_next;
        div_a <= grc_pkg::DIV_W'(1) << 32;
        div_b <= grc_pkg::DVS_W'(rx_next[grc_pkg::RAY_W-1] ? -rx_next : rx_next);
      end
      S_DDX: begin
        if (div_done) begin
          ddx   <= (rx == '0) ? grc_pkg::DELTA_SAT : div_q[grc_pkg::DD_W-1:0];
          div_b <= grc_pkg::DVS_W'(ry_mag);
        end
      end
      S_DDY: begin
        if (div_done) begin
          ddy <= (ry == '0) ? grc_pkg::DELTA_SAT : div_q[grc_pkg::DD_W-1:0];
        end
      end
      S_SIDE: begin
        sdx  <= grc_pkg::SD_W'(fxc) * grc_pkg::SD_W'(ddx);
        sdy  <= grc_pkg::SD_W'(fyc) * grc_pkg::SD_W'(ddy);
        mx   <= grc_pkg::MX_W'(cfg.pos_x[20:16]);
        my   <= grc_pkg::MX_W'(cfg.pos_y[20:16]);
        iter <= '0;
        side <= 1'b0;
      end
      S_STEP: begin
        if (step_x) begin
          sdx  <= sdx + (grc_pkg::SD_W'(ddx) << 16);
          side <= 1'b0;
        end else begin
          sdy  <= sdy + (grc_pkg::SD_W'(ddy) << 16);
          side <= 1'b1;
        end
        mx <= mx_next;
        my <= my_next;
      end
      S_LOOK: begin
        iter <= iter + 1'b1;
        code <= (outside || (rd_data == '0)) ? grc_pkg::OUTSIDE_CODE : rd_data;
      end
      S_NUM: begin
        rd_zero <= side ? (ry == '0) : (rx == '0);
        div_a   <= grc_pkg::DIV_W'(num_mag) << 16;
        div_b   <= grc_pkg::DVS_W'(side ? ry_mag : rx_mag);
      end
      S_PERP: begin
        if (div_done) begin
          perp  <= perp_val;
          div_a <= grc_pkg::DIV_W'(SCREEN_HEIGHT) << 16;
          div_b <= grc_pkg::DVS_W'(perp_val);
        end
      end
      S_LH: if (div_done) lh <= lh_val;
      S_SPAN: begin
        span_start <= start_val[8:0];
        span_end   <= end_val[8:0];
        prod_w     <= PW_W'(signed'({1'b0, perp})) * PW_W'(side ? rx : ry);
      end
      S_TEX: begin
        result.hit_code       <= code;
        result.hit_x          <= mx[4:0];
        result.hit_y          <= my[4:0];
        result.hit_side       <= side;
        result.wall_face      <= face;
        result.perp_distance  <= perp;
        result.line_height    <= lh;
        result.span_start     <= span_start;
        result.span_end       <= span_end;
        result.texture_column <= tex_raw[5:0];
      end
      default: ;
    endcase
  end

`ifndef SYNTH
  a_single_strobe: assert property (@(posedge clk) disable iff (rst)
    result_valid |=> !result_valid)
    else $error("result strobe lasted more than one cycle");

  a_take_idle: assert property (@(posedge clk) disable iff (rst)
    take |-> (state == S_IDLE))
    else $error("queue popped outside idle");

  a_write_window: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> ((state == S_CLEAR) || (state == S_IDLE)))
    else $error("grid written during a cast");

  a_div_done_wait: assert property (@(posedge clk) disable iff (rst)
    div_done |-> ((state == S_DDX) || (state == S_DDY)
                  || (state == S_PERP) || (state == S_LH)))
    else $error("divider finished while not awaited");
`endif

endmodule
